// ----- design/pbc_pkg.sv -----
// Shared constants and types for the pileup base counter.
package pbc_pkg;

  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_W           = 16;
  localparam int DEPTH_W         = 18;
  localparam int CHAR_W          = 8;

  // One classified byte handed from the parser to the counter.
  typedef struct packed {
    logic       bump;
    logic [1:0] idx;
    logic       last;
  } op_t;

endpackage

// ----- design/pbc_if.sv -----
// Valid/ready channels for column bytes and column results.
interface pbc_column_if;
  logic                          valid;
  logic                          ready;
  logic [pbc_pkg::CHAR_W-1:0]    base_char;
  logic [pbc_pkg::CHAR_W-1:0]    ref_base;
  logic                          last;

  modport source (output valid, base_char, ref_base, last, input ready);
  modport sink   (input valid, base_char, ref_base, last, output ready);
endinterface

interface pbc_result_if;
  logic                        valid;
  logic                        ready;
  logic [pbc_pkg::OUT_W-1:0]   count_a;
  logic [pbc_pkg::OUT_W-1:0]   count_c;
  logic [pbc_pkg::OUT_W-1:0]   count_g;
  logic [pbc_pkg::OUT_W-1:0]   count_t;
  logic                        covered;

  modport source (output valid, count_a, count_c, count_g, count_t, covered, input ready);
  modport sink   (input valid, count_a, count_c, count_g, count_t, covered, output ready);
endinterface

// ----- design/pileup_base_counter.sv -----
// Top level of the pileup column base counter.
//
// Usage:
//   column: one read-base byte per request, with the column's reference base
//     and a last flag on the final byte. Every column has at least one byte.
//   result: one request per column, carrying the four base counts and a
//     covered flag (count sum >= min_depth).
//   min_depth_we / min_depth_wdata: write the minimum depth register while
//     the block is idle.
// Throughput: one byte per cycle while the queue is not full. The parser
//   classifies a byte in the cycle it is taken and hands it through a small
//   queue to the counter stage.
// Column end: the last byte is written into the queue when it is taken; the
//   counter then pops it and loads the final counts into the result register.
// Reset: parse state, counts, queue and min_depth clear to zero.
// Stall: while a result waits, the counter keeps absorbing bytes of the next
//   column; it halts only at that column's last byte, and the parser halts
//   once the queue fills, dropping column ready.
module pileup_base_counter #(
  parameter int COUNT_BITS  = pbc_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = pbc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         min_depth_we,
  input  logic [pbc_pkg::DEPTH_W-1:0]  min_depth_wdata,
  pbc_column_if.sink                   column,
  pbc_result_if.source                 result
);

  logic         push, pop, full, empty;
  pbc_pkg::op_t push_op, head;

  pbc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .column     (column),
    .queue_full (full),
    .push       (push),
    .push_op    (push_op)
  );

  pbc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  pbc_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .min_depth_we    (min_depth_we),
    .min_depth_wdata (min_depth_wdata),
    .empty           (empty),
    .head            (head),
    .pop             (pop),
    .result          (result)
  );

endmodule

// ----- design/pbc_front.sv -----
// Byte parser: tracks skip and indel state and classifies each byte.
module pbc_front (
  input  logic               clk,
  input  logic               rst,
  pbc_column_if.sink         column,
  input  logic               queue_full,
  output logic               push,
  output pbc_pkg::op_t       push_op
);

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_SKIP   = 2'd1;
  localparam logic [1:0] MODE_DIGITS = 2'd2;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // {valid, index} for A C G T in either case
  function automatic logic [2:0] base_code(input logic [7:0] ch);
    logic [2:0] code;
    case (ch)
      8'h41, 8'h61: code = 3'b100;
      8'h43, 8'h63: code = 3'b101;
      8'h47, 8'h67: code = 3'b110;
      8'h54, 8'h74: code = 3'b111;
      default:      code = 3'b000;
    endcase
    return code;
  endfunction

  logic [1:0]  mode, mode_next;
  logic [15:0] indel_length, indel_next;
  logic [15:0] skip_left, skip_next;
  logic [15:0] skip_dec;
  logic [19:0] prod;
  logic [3:0]  digit;
  logic        is_digit;
  logic [2:0]  ch_code, ref_code;
  logic        op_bump;
  logic [1:0]  op_idx;
  logic        accept;

  assign column.ready = !queue_full;
  assign accept       = column.valid && column.ready;
  assign is_digit     = column.base_char >= CH_ZERO && column.base_char <= CH_NINE;
  assign digit        = 4'(column.base_char - CH_ZERO);
  assign ch_code      = base_code(column.base_char);
  assign ref_code     = base_code(column.ref_base);
  assign prod         = 20'(indel_length) * 20'd10 + 20'(digit);
  assign skip_dec     = (skip_left != 16'd0) ? skip_left - 16'd1 : 16'd0;

  always_comb begin
    mode_next  = mode;
    indel_next = indel_length;
    skip_next  = skip_left;
    op_bump    = 1'b0;
    op_idx     = 2'd0;
    case (mode)
      MODE_DIGITS: begin
        if (is_digit) begin
          indel_next = (prod > 20'(LEN_MAX)) ? LEN_MAX : prod[15:0];
        end else begin
          // this byte is the first skipped one
          skip_next  = (indel_length == 16'd0) ? 16'd0 : indel_length - 16'd1;
          indel_next = 16'd0;
          mode_next  = (skip_next != 16'd0) ? MODE_SKIP : MODE_NORMAL;
        end
      end
      MODE_SKIP: begin
        skip_next = skip_dec;
        if (skip_dec == 16'd0) begin
          mode_next = MODE_NORMAL;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
        if (column.base_char == CH_DOLLAR) begin
          mode_next = MODE_NORMAL;
        end else if (column.base_char == CH_CARET) begin
          skip_next = 16'd1;
          mode_next = MODE_SKIP;
        end else if (column.base_char == CH_PLUS || column.base_char == CH_MINUS) begin
          indel_next = 16'd0;
          mode_next  = MODE_DIGITS;
        end else if (column.base_char == CH_COMMA || column.base_char == CH_DOT) begin
          op_bump = ref_code[2];
          op_idx  = ref_code[1:0];
        end else begin
          op_bump = ch_code[2];
          op_idx  = ch_code[1:0];
        end
      end
    endcase
    if (column.last) begin
      mode_next  = MODE_NORMAL;
      indel_next = 16'd0;
      skip_next  = 16'd0;
    end
  end

  assign push         = accept && (op_bump || column.last);
  assign push_op.bump = op_bump;
  assign push_op.idx  = op_idx;
  assign push_op.last = column.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      indel_length <= 16'd0;
      skip_left    <= 16'd0;
    end else if (accept) begin
      mode         <= mode_next;
      indel_length <= indel_next;
      skip_left    <= skip_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && column.last |=> mode == MODE_NORMAL && skip_left == 16'd0
                              && indel_length == 16'd0)
    else $error("parse state not cleared after column end");

endmodule

// ----- design/pbc_queue.sv -----
// Small FIFO of classified bytes between parser and counter.
module pbc_queue #(
  parameter int DEPTH = pbc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pbc_pkg::op_t  push_op,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output pbc_pkg::op_t  head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pbc_pkg::op_t mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("pop from empty queue");

endmodule

// ----- design/pbc_back.sv -----
// Base counters, depth compare and result register.
module pbc_back #(
  parameter int COUNT_BITS = pbc_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         min_depth_we,
  input  logic [pbc_pkg::DEPTH_W-1:0]  min_depth_wdata,
  input  logic                         empty,
  input  pbc_pkg::op_t                 head,
  output logic                         pop,
  pbc_result_if.source                 result
);

  localparam int SUM_W = COUNT_BITS + 2;
  localparam int CMP_W = (SUM_W > pbc_pkg::DEPTH_W) ? SUM_W : pbc_pkg::DEPTH_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [pbc_pkg::DEPTH_W-1:0] min_depth;
  logic [COUNT_BITS-1:0]       counts [4];
  logic [COUNT_BITS-1:0]       counts_next [4];
  logic [CMP_W-1:0]            sum;
  logic                        res_valid;
  logic                        load;

  assign pop  = !empty && !(head.last && res_valid && !result.ready);
  assign load = pop && head.last;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      counts_next[i] = counts[i];
      if (head.bump && head.idx == 2'(i) && counts[i] != COUNT_MAX) begin
        counts_next[i] = counts[i] + COUNT_BITS'(1);
      end
    end
  end

  assign sum = CMP_W'(counts_next[0]) + CMP_W'(counts_next[1])
             + CMP_W'(counts_next[2]) + CMP_W'(counts_next[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_depth <= '0;
    end else if (min_depth_we) begin
      min_depth <= min_depth_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        counts[i] <= '0;
      end
    end else if (pop) begin
      for (int i = 0; i < 4; i++) begin
        counts[i] <= head.last ? '0 : counts_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.count_a <= pbc_pkg::OUT_W'(counts_next[0]);
      result.count_c <= pbc_pkg::OUT_W'(counts_next[1]);
      result.count_g <= pbc_pkg::OUT_W'(counts_next[2]);
      result.count_t <= pbc_pkg::OUT_W'(counts_next[3]);
      result.covered <= sum >= CMP_W'(min_depth);
    end
  end

  assign result.valid = res_valid;

  a_counts_clear: assert property (@(posedge clk) disable iff (rst)
    load |=> counts[0] == '0 && counts[1] == '0 && counts[2] == '0 && counts[3] == '0)
    else $error("counts not cleared after column end");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(load))
    else $error("result raised without a column end");

endmodule
